// ===== rtl/psf_pkg.sv =====
// shared types, constants and microcode for the predicate stream filter
`timescale 1ns / 1ps
`default_nettype none

package psf_pkg;

  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 11;
  localparam int MAX_ITEMS = 1024;
  localparam int COUNT_FIELD_MAX = (1 << COUNT_W) - 1;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT =
      (MAX_ITEMS > COUNT_FIELD_MAX) ? COUNT_W'(COUNT_FIELD_MAX) : COUNT_W'(MAX_ITEMS);

  // trial divisors stay below 2^16 while d*d <= value < 2^31
  localparam int DIV_W  = 16;
  localparam int SQ_W   = 32;
  localparam int STEP_W = 18;

  // remainder unit retires this many dividend bits per cycle while ctrl.step is high
  localparam int REM_BITS_PER_CYCLE = 4;
  localparam int REM_CYCLES = VALUE_W / REM_BITS_PER_CYCLE;
  localparam int REM_CNT_W  = $clog2(REM_CYCLES);

  // mod-five fold: sum of eight nibbles fits 7 bits, its folded form 5 bits
  localparam int MOD5_SUM_W = 7;
  localparam int MOD5_RES_W = 5;

  localparam logic [DIV_W-1:0]   DIV_TWO   = DIV_W'(2);
  localparam logic [SQ_W-1:0]    SQ_TWO    = SQ_W'(4);
  localparam logic [SQ_W-1:0]    SQ_TWO_TO_THREE = SQ_W'(5);
  localparam logic [VALUE_W-1:0] BELOW_LIMIT = VALUE_W'(100);
  localparam logic [VALUE_W-1:0] PRIME_MIN   = VALUE_W'(2);

  typedef enum logic [1:0] {
    MODE_DIV5     = 2'd0,
    MODE_BELOW100 = 2'd1,
    MODE_PRIME    = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  localparam mode_t MODE_RESET = MODE_PRIME;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SETUP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_CHECK,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_FIRE,
    C_SIMPLE,
    C_PRIME_DONE,
    C_DIV_LAST,
    C_LOOP_AGAIN,
    C_OUT_FREE
  } cond_t;

  localparam int UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_LOAD      = 3'd0;
  localparam upc_t UPC_SETUP     = 3'd1;
  localparam upc_t UPC_DIV_INIT  = 3'd2;
  localparam upc_t UPC_DIV_STEP  = 3'd3;
  localparam upc_t UPC_DIV_CHECK = 3'd4;
  localparam upc_t UPC_EMIT      = 3'd5;

  // hold: stay on this step while the condition is false
  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
    logic  hold;
  } ucw_t;

  typedef struct packed {
    logic init;
    logic step;
  } rem_ctrl_t;

  function automatic ucw_t ucode_rom(upc_t pc);
    ucw_t w;
    unique case (pc)
      UPC_LOAD:      w = '{op: OP_LOAD,      cond: C_IN_FIRE,    target: UPC_SETUP,     hold: 1'b1};
      UPC_SETUP:     w = '{op: OP_SETUP,     cond: C_SIMPLE,     target: UPC_EMIT,      hold: 1'b0};
      UPC_DIV_INIT:  w = '{op: OP_DIV_INIT,  cond: C_PRIME_DONE, target: UPC_EMIT,      hold: 1'b0};
      UPC_DIV_STEP:  w = '{op: OP_DIV_STEP,  cond: C_DIV_LAST,   target: UPC_DIV_CHECK, hold: 1'b1};
      UPC_DIV_CHECK: w = '{op: OP_DIV_CHECK, cond: C_LOOP_AGAIN, target: UPC_DIV_INIT,  hold: 1'b0};
      UPC_EMIT:      w = '{op: OP_EMIT,      cond: C_OUT_FREE,   target: UPC_LOAD,      hold: 1'b1};
      default:       w = '{op: OP_NOP,       cond: C_ALWAYS,     target: UPC_LOAD,      hold: 1'b0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/psf_rem_unit.sv =====
// iterative remainder unit, four dividend bits per cycle while ctrl.step is high
`timescale 1ns / 1ps
`default_nettype none

module psf_rem_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire psf_pkg::rem_ctrl_t        ctrl,
  input  wire logic [psf_pkg::VALUE_W-1:0] dividend,
  input  wire logic [psf_pkg::DIV_W-1:0]   divisor,
  output logic      [psf_pkg::DIV_W-1:0]   rem,
  output logic                           last
);
  import psf_pkg::*;

  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [VALUE_W-1:0]   quo_r, quo_nxt;
  logic [REM_CNT_W-1:0] cnt_r, cnt_nxt;

  logic [DIV_W-1:0]   rem_it;
  logic [VALUE_W-1:0] quo_it;
  logic [DIV_W:0]     part;

  // restoring steps: remainder stays below divisor, so part fits DIV_W+1 bits
  always_comb begin
    rem_it = rem_r;
    quo_it = quo_r;
    part   = '0;
    for (int i = 0; i < REM_BITS_PER_CYCLE; i++) begin
      part   = {rem_it, quo_it[VALUE_W-1]};
      quo_it = {quo_it[VALUE_W-2:0], 1'b0};
      if (part >= {1'b0, divisor}) begin
        part = part - {1'b0, divisor};
      end
      rem_it = part[DIV_W-1:0];
    end
  end

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (ctrl.init) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = '0;
    end else if (ctrl.step) begin
      rem_nxt = rem_it;
      quo_nxt = quo_it;
      cnt_nxt = cnt_r + REM_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rem  = rem_r;
  assign last = (cnt_r == REM_CNT_W'(REM_CYCLES - 1));

endmodule

`default_nettype wire

// ===== rtl/predicate_stream_filter.sv =====
// top level: microcoded stream filter with divisible-by-five, below-100 and prime tests
//
// Input channel in_*: one word per item (in_value, in_last_item), taken when
// in_valid is high and in_stall low. Result channel out_*: one word per item
// with the value, keep flag, running kept count and end-of-array echo, taken
// when out_valid is high and out_stall low. cfg_filter_mode is written with
// cfg_valid/cfg_ready (ready always high); write it only while idle.
// Items are processed one at a time by a six-step microprogram: load,
// setup, then emit in divisible-by-five, below-100 and unused modes; in
// prime mode setup is followed by a loop over trial divisors (2 and the
// odd numbers up to sqrt(value)), each with a setup step, remainder-unit
// steps up to the last one and a check step, left for emit once d*d exceeds
// the value, the value is below two or a divisor is found. The next item
// can be taken in the cycle after the result is loaded into the output
// register, even while that result still waits.
// If the receiver stalls, the result holds in the output register and the
// sequencer waits on its emit step.
// Reset (synchronous, rst_n low) sets the mode to prime, clears the kept
// count and returns the sequencer to its load step.
`timescale 1ns / 1ps
`default_nettype none

module predicate_stream_filter (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [psf_pkg::VALUE_W-1:0] in_value,
  input  wire logic                               in_last_item,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed      [psf_pkg::VALUE_W-1:0] out_value_out,
  output logic                                    out_keep,
  output logic             [psf_pkg::COUNT_W-1:0] out_kept_total,
  output logic                                    out_end_of_array,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic        [1:0]                  cfg_filter_mode
);
  import psf_pkg::*;

  upc_t  upc_r, upc_nxt;
  mode_t mode_r;
  ucw_t  w;

  logic [VALUE_W-1:0] value_r, value_nxt;
  logic               last_r, last_nxt;
  logic               match_r, match_nxt;
  logic [VALUE_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0]   div_r, div_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [COUNT_W-1:0] kept_r, kept_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_keep_r, out_keep_nxt;
  logic [COUNT_W-1:0] out_total_r, out_total_nxt;
  logic               out_eoa_r, out_eoa_nxt;

  logic               in_fire, out_fire, out_free, cond_true;
  logic               is_simple, prime_done, loop_again, rem_zero;
  logic [MOD5_SUM_W-1:0] nib_sum;
  logic [MOD5_RES_W-1:0] res5;
  logic               div5_hit;
  logic [COUNT_W-1:0] total;
  logic [STEP_W-1:0]  sq_step;

  rem_ctrl_t          rem_ctrl;
  logic [DIV_W-1:0]   rem;
  logic               rem_last;

  psf_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (rem_ctrl),
    .dividend (dvd_r),
    .divisor  (div_r),
    .rem      (rem),
    .last     (rem_last)
  );

  assign w         = ucode_rom(upc_r);
  assign in_stall  = (upc_r != UPC_LOAD);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // 16 is 1 mod 5, so the nibble sum keeps the residue of the word
  always_comb begin
    nib_sum = '0;
    for (int i = 0; i < VALUE_W / 4; i++) begin
      nib_sum = nib_sum + MOD5_SUM_W'(value_r[4*i +: 4]);
    end
    res5 = MOD5_RES_W'(nib_sum[MOD5_SUM_W-1:4]) + MOD5_RES_W'(nib_sum[3:0]);
    if (res5 >= MOD5_RES_W'(20)) begin
      res5 = res5 - MOD5_RES_W'(20);
    end
    if (res5 >= MOD5_RES_W'(10)) begin
      res5 = res5 - MOD5_RES_W'(10);
    end
    if (res5 >= MOD5_RES_W'(5)) begin
      res5 = res5 - MOD5_RES_W'(5);
    end
  end

  // 2^32 is 1 mod 5: a negative word's magnitude is a multiple of five when its bits leave 1
  assign div5_hit   = value_r[VALUE_W-1] ? (res5 == MOD5_RES_W'(1)) : (res5 == '0);

  assign rem_zero   = (rem == '0);
  assign is_simple  = (mode_r == MODE_BELOW100) || (mode_r == MODE_NONE) ||
                      (mode_r == MODE_DIV5);
  // negative or below two ends the prime test at once, as does d*d > value
  assign prime_done = (mode_r == MODE_PRIME) &&
                      (value_r[VALUE_W-1] || (value_r < PRIME_MIN) || (sq_r > value_r));
  assign loop_again = (mode_r == MODE_PRIME) && !rem_zero;
  // (d+2)^2 - d^2 for odd divisors
  assign sq_step    = {div_r, 2'b00} + STEP_W'(4);
  assign total      = kept_r + COUNT_W'(!match_r && (kept_r < COUNT_LIMIT));

  assign rem_ctrl.init = (w.op == OP_DIV_INIT);
  assign rem_ctrl.step = (w.op == OP_DIV_STEP);

  always_comb begin
    unique case (w.cond)
      C_ALWAYS:     cond_true = 1'b1;
      C_IN_FIRE:    cond_true = in_fire;
      C_SIMPLE:     cond_true = is_simple;
      C_PRIME_DONE: cond_true = prime_done;
      C_DIV_LAST:   cond_true = rem_last;
      C_LOOP_AGAIN: cond_true = loop_again;
      C_OUT_FREE:   cond_true = out_free;
      default:      cond_true = 1'b1;
    endcase
  end

  always_comb begin
    priority if (cond_true) begin
      upc_nxt = w.target;
    end else if (w.hold) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + UPC_W'(1);
    end
  end

  always_comb begin
    value_nxt     = value_r;
    last_nxt      = last_r;
    match_nxt     = match_r;
    dvd_nxt       = dvd_r;
    div_nxt       = div_r;
    sq_nxt        = sq_r;
    kept_nxt      = kept_r;
    out_value_nxt = out_value_r;
    out_keep_nxt  = out_keep_r;
    out_total_nxt = out_total_r;
    out_eoa_nxt   = out_eoa_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;

    unique case (w.op)
      OP_LOAD: begin
        if (in_fire) begin
          value_nxt = in_value;
          last_nxt  = in_last_item;
        end
      end
      OP_SETUP: begin
        dvd_nxt = value_r;
        div_nxt = DIV_TWO;
        sq_nxt  = SQ_TWO;
        unique case (mode_r)
          MODE_DIV5:     match_nxt = div5_hit;
          MODE_BELOW100: match_nxt = value_r[VALUE_W-1] || (value_r < BELOW_LIMIT);
          MODE_PRIME:    match_nxt = !value_r[VALUE_W-1] && (value_r >= PRIME_MIN);
          MODE_NONE:     match_nxt = 1'b0;
          default:       match_nxt = 1'b0;
        endcase
      end
      OP_DIV_CHECK: begin
        if (rem_zero) begin
          // divisor found: composite
          match_nxt = 1'b0;
        end
        if (div_r == DIV_TWO) begin
          div_nxt = div_r + DIV_W'(1);
          sq_nxt  = sq_r + SQ_TWO_TO_THREE;
        end else begin
          div_nxt = div_r + DIV_W'(2);
          sq_nxt  = sq_r + SQ_W'(sq_step);
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = value_r;
          out_keep_nxt  = !match_r;
          out_total_nxt = total;
          out_eoa_nxt   = last_r;
          kept_nxt      = last_r ? '0 : total;
        end
      end
      OP_NOP, OP_DIV_INIT, OP_DIV_STEP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= UPC_LOAD;
      mode_r      <= MODE_RESET;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      kept_r      <= kept_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= mode_t'(cfg_filter_mode);
      end
    end
    value_r     <= value_nxt;
    last_r      <= last_nxt;
    match_r     <= match_nxt;
    dvd_r       <= dvd_nxt;
    div_r       <= div_nxt;
    sq_r        <= sq_nxt;
    out_value_r <= out_value_nxt;
    out_keep_r  <= out_keep_nxt;
    out_total_r <= out_total_nxt;
    out_eoa_r   <= out_eoa_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_value_out    = out_value_r;
  assign out_keep         = out_keep_r;
  assign out_kept_total   = out_total_r;
  assign out_end_of_array = out_eoa_r;

endmodule

`default_nettype wire

// ===== rtl/psf_checker.sv =====
// port-level checker for the predicate stream filter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module psf_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic                               in_stall,
  input  wire logic                               out_valid,
  input  wire logic                               out_stall,
  input  wire logic                               out_keep,
  input  wire logic        [psf_pkg::COUNT_W-1:0] out_kept_total,
  input  wire logic                               out_end_of_array
);
  import psf_pkg::*;

  logic               in_fire, out_fire;
  logic [1:0]         pend_r, pend_nxt;
  logic [COUNT_W-1:0] prev_total_r;
  logic               prev_eoa_r;
  logic [COUNT_W-1:0] base, expect_total;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign pend_nxt = pend_r + 2'(in_fire) - 2'(out_fire);

  // count of the current array before this word
  assign base         = prev_eoa_r ? '0 : prev_total_r;
  assign expect_total = base + COUNT_W'(out_keep && (base < COUNT_LIMIT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= '0;
      prev_total_r <= '0;
      prev_eoa_r   <= 1'b1;
    end else begin
      pend_r <= pend_nxt;
      if (out_fire) begin
        prev_total_r <= out_kept_total;
        prev_eoa_r   <= out_end_of_array;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> out_kept_total == expect_total)
    else $error("kept count does not follow keep flags");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without an accepted word");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kept_total <= COUNT_LIMIT)
    else $error("kept count above limit");

endmodule

bind predicate_stream_filter psf_checker u_psf_checker (.*);

`default_nettype wire
